[sv/wpo_pkg.sv]
// Shared types and constants for the waveform peak overview block.
// No dependencies; imported by the top level and the peak memory.
package wpo_pkg;

	localparam int PEAK_W    = 16;
	localparam int OUT_CNT_W = 13;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_BLOCK_FRAMES  = 2'd0,
		REG_CHANNEL_COUNT = 2'd1,
		REG_DISPLAY_WIDTH = 2'd2,
		REG_UNUSED        = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_DATA  = 2'd1,
		ST_RANGE    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage

[sv/wpo_div.sv]
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the top level to find the pixel's block range.
module wpo_div #(
	parameter int DIVIDEND_W = 26,
	parameter int DIVISOR_W  = 13
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    rem_shift;
	logic                  fits;

	assign rem_shift = {rem_q, dq_q[DIVIDEND_W-1]};
	assign fits      = rem_shift >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dq_q   <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
				rem_q  <= '0;
				dq_q   <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= DIVISOR_W'(rem_shift - {1'b0, dvs_q});
				end else begin
					rem_q <= rem_shift[DIVISOR_W-1:0];
				end
				dq_q  <= {dq_q[DIVIDEND_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

[sv/wpo_peak_mem.sv]
// Block peak memory: one write port, one read port with registered data.
// Depends on wpo_pkg for the peak width.
module wpo_peak_mem
	import wpo_pkg::*;
#(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [PEAK_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [PEAK_W-1:0] rdata
);

	logic [PEAK_W-1:0] mem [DEPTH];
	logic [PEAK_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/waveform_peak_overview_top.sv]
// Top level of the waveform peak overview: sample intake, peak memory, query sequencer.
// Depends on wpo_pkg, wpo_div and wpo_peak_mem.
//
// Audio samples (command 1) are taken one per cycle while no query is running:
// the magnitude of each sample is folded into a running block peak, and when
// the block holds block_frames * channel_count samples, or the sample carries
// the last mark, the peak is written to the peak memory at the next free slot.
// When the memory holds MAX_BLOCKS peaks, further blocks are dropped and the
// overflow status sticks until a clear (command 0). A pixel query (command 2)
// runs on a sequencer and holds in_ready low until its result is loaded into
// the output register. The sequencer uses one multiplier and one restoring
// divider twice, for start = i*n/w and end = (i+1)*n/w; each dividend is
// DW = 13 + clog2(MAX_BLOCKS+1) bits wide (26 at the default). The range is
// then scanned one peak per cycle through the memory's registered read port.
// A query with no data or a pixel beyond display_width skips the multiplier,
// divider and scan and goes straight to its result. Any query waits while
// the output register still holds an earlier result nobody has taken.
// A finished result waits in the output register, and samples and clears are
// still taken while it waits. Configuration should be written only while the
// block is idle; the block itself does not enforce this. cfg_ready is always
// high. A zero register value is treated as one, and a channel count above
// eight as eight.
module waveform_peak_overview_top
	import wpo_pkg::*;
#(
	parameter int MAX_BLOCKS  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	// input items
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   sample_last,
	input  logic [11:0]            pixel_index,
	// result items
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [15:0]            pixel_peak,
	output logic [12:0]            stored_blocks,
	output logic [1:0]             status
);

	localparam int CW  = $clog2(MAX_BLOCKS + 1);  // block count, reaches MAX_BLOCKS
	localparam int AW  = $clog2(MAX_BLOCKS);      // memory address
	localparam int DW  = 13 + CW;                 // (i+1)*n
	localparam int MW  = (SAMPLE_BITS > PEAK_W) ? SAMPLE_BITS : PEAK_W;
	localparam int SBW = 19;                      // samples in block

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_LO,
		S_DIV_LO,
		S_MUL_HI,
		S_DIV_HI,
		S_SCAN,
		S_DONE
	} state_t;

	// configuration registers
	logic [15:0] block_frames_q;
	logic [3:0]  channel_count_q;
	logic [12:0] display_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_frames_q  <= 16'd1024;
			channel_count_q <= 4'd2;
			display_width_q <= 13'd512;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BLOCK_FRAMES:  block_frames_q  <= cfg_data;
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[3:0];
				REG_DISPLAY_WIDTH: display_width_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// effective settings
	logic [15:0]  frames_eff;
	logic [3:0]   chans_eff;
	logic [12:0]  width_eff;
	logic [SBW-1:0] target;

	assign frames_eff = (block_frames_q == 16'd0) ? 16'd1 : block_frames_q;
	assign chans_eff  = (channel_count_q == 4'd0) ? 4'd1 :
	                    (channel_count_q > 4'd8)  ? 4'd8 : channel_count_q;
	assign width_eff  = (display_width_q == 13'd0) ? 13'd1 : display_width_q;
	assign target     = SBW'(frames_eff) * SBW'(chans_eff);

	// sequencer and block state
	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [PEAK_W-1:0] run_q;
	logic [SBW-1:0]    cnt_q;
	logic              ovf_q;
	logic [11:0]       pix_q;
	logic [DW-1:0]     prod_q;
	logic              div_go_q;
	logic [CW-1:0]     start_q;
	logic [CW-1:0]     end_q;
	logic [CW-1:0]     addr_q;
	logic              pend_q;
	logic [PEAK_W-1:0] peak_q;
	logic [1:0]        res_status_q;
	logic              out_valid_q;
	logic [15:0]       pixel_peak_q;
	logic [12:0]       stored_q;
	logic [1:0]        status_q;

	logic in_fire;
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	// result moves into the output register once that register is free
	logic res_load;
	assign res_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// sample magnitude, most negative code maps to 2^(SAMPLE_BITS-1)
	logic [SAMPLE_BITS-1:0] mag_full;
	logic [MW-1:0]          mag_ext;
	logic [PEAK_W-1:0]      mag;
	logic [PEAK_W-1:0]      peak_new;
	logic [SBW-1:0]         cnt_inc;
	logic                   blk_end;
	logic                   has_room;
	logic                   mem_we;

	assign mag_full = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
	assign mag_ext  = MW'(mag_full);
	assign mag      = (mag_ext > MW'({PEAK_W{1'b1}})) ? {PEAK_W{1'b1}} : mag_ext[PEAK_W-1:0];
	assign peak_new = (mag > run_q) ? mag : run_q;
	assign cnt_inc  = cnt_q + 1'b1;
	assign blk_end  = (cnt_inc >= target) || sample_last;
	assign has_room = count_q < CW'(MAX_BLOCKS);
	assign mem_we   = in_fire && (cmd_t'(command) == CMD_SAMPLE) && blk_end && has_room;

	// shared multiplier: i*n, then (i+1)*n
	logic [12:0]   mul_a;
	logic [DW-1:0] prod;
	assign mul_a = (state_q == S_MUL_HI) ? ({1'b0, pix_q} + 13'd1) : {1'b0, pix_q};
	assign prod  = DW'(mul_a) * DW'(count_q);

	logic          div_done;
	logic [DW-1:0] quot;

	wpo_div #(
		.DIVIDEND_W(DW),
		.DIVISOR_W (13)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_go_q),
		.dividend(prod_q),
		.divisor (width_eff),
		.done    (div_done),
		.quotient(quot)
	);

	logic [PEAK_W-1:0] rd_data;

	wpo_peak_mem #(
		.DEPTH(MAX_BLOCKS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(count_q[AW-1:0]),
		.wdata(peak_new),
		.raddr(addr_q[AW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			run_q        <= '0;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			pix_q        <= '0;
			prod_q       <= '0;
			div_go_q     <= 1'b0;
			start_q      <= '0;
			end_q        <= '0;
			addr_q       <= '0;
			pend_q       <= 1'b0;
			peak_q       <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
			pixel_peak_q <= '0;
			stored_q     <= '0;
			status_q     <= ST_OK;
		end else begin
			div_go_q <= 1'b0;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						unique case (cmd_t'(command))
							CMD_CLEAR: begin
								count_q <= '0;
								run_q   <= '0;
								cnt_q   <= '0;
								ovf_q   <= 1'b0;
							end
							CMD_SAMPLE: begin
								if (blk_end) begin
									run_q <= '0;
									cnt_q <= '0;
									if (has_room) begin
										count_q <= count_q + 1'b1;
									end else begin
										ovf_q <= 1'b1;
									end
								end else begin
									run_q <= peak_new;
									cnt_q <= cnt_inc;
								end
							end
							CMD_QUERY: begin
								pix_q  <= pixel_index;
								peak_q <= '0;
								if (count_q == '0) begin
									res_status_q <= ST_NO_DATA;
									state_q      <= S_DONE;
								end else if ({1'b0, pixel_index} >= width_eff) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= ovf_q ? ST_OVERFLOW : ST_OK;
									state_q      <= S_MUL_LO;
								end
							end
							default: ;
						endcase
					end
				end
				S_MUL_LO: begin
					prod_q   <= prod;
					div_go_q <= 1'b1;
					state_q  <= S_DIV_LO;
				end
				S_DIV_LO: begin
					if (div_done) begin
						start_q <= quot[CW-1:0];
						state_q <= S_MUL_HI;
					end
				end
				S_MUL_HI: begin
					prod_q   <= prod;
					div_go_q <= 1'b1;
					state_q  <= S_DIV_HI;
				end
				S_DIV_HI: begin
					if (div_done) begin
						end_q   <= (quot > DW'(count_q)) ? count_q : quot[CW-1:0];
						addr_q  <= start_q;
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one read issued per cycle, data compared once the read port's register returns it
					if (pend_q && (rd_data > peak_q)) begin
						peak_q <= rd_data;
					end
					if (addr_q < end_q) begin
						addr_q <= addr_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (res_load) begin
						pixel_peak_q <= peak_q;
						stored_q     <= OUT_CNT_W'(count_q);
						status_q     <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_peak    = pixel_peak_q;
	assign stored_blocks = stored_q;
	assign status        = status_q;

	// the block count never runs past the memory
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_BLOCKS))
		else $error("block count beyond memory depth");

	// scan pointer never passes the end of the range being searched
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (addr_q <= end_q))
		else $error("scan address past range end");

	// divider results only arrive while the sequencer waits for them
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_LO || state_q == S_DIV_HI))
		else $error("divider done outside a division step");

	// a no-data or out-of-range answer carries a zero peak
	a_zero_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_NO_DATA || status_q == ST_RANGE))
		|-> (pixel_peak_q == '0))
		else $error("nonzero peak with error status");

	// nothing is written to the memory while a query reads it
	a_no_write_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_IDLE))
		else $error("peak write during query");

endmodule

[dv/tb_top.sv]
// Self-checking bench for waveform_peak_overview_top: block peak intake, pixel queries, status.
// Depends on wpo_pkg and the RTL top level only; no files, no arguments.
`timescale 1ns / 1ps

module tb_top;
	import wpo_pkg::*;

	localparam int PEAK_SLOTS     = 4096;
	localparam int FILL_BLOCKS    = 900;    // one-sample blocks in the long fill run
	localparam int SETTLE_CYCLES  = 16;     // sample write-back may still be in flight
	localparam int HOLD_CYCLES    = 400;    // long output hold-off, fills the block up
	localparam int WATCHDOG_LIMIT = 20000;  // longer than a full-memory scan

	typedef struct {
		cmd_t        cmd;
		logic [15:0] smp;
		logic        last;
		logic [11:0] pix;
	} audio_item_t;

	typedef struct {
		logic [11:0] pix;      // for the report only
		logic [15:0] peak;
		logic [12:0] blocks;
		status_t     st;
	} pixel_result_t;

	typedef struct {
		reg_idx_t    idx;
		logic [15:0] data;
	} reg_write_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLE} rx_pattern_t;

	// clock and DUT pins, all known from time zero
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index   = '0;
	logic [15:0] cfg_data    = '0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [1:0]  command     = '0;
	logic [15:0] sample      = '0;
	logic        sample_last = 1'b0;
	logic [11:0] pixel_index = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [15:0] pixel_peak;
	logic [12:0] stored_blocks;
	logic [1:0]  status;

	// stimulus and expectation stores
	audio_item_t   pend_items[$];
	reg_write_t    pend_regs[$];
	pixel_result_t expected_peaks[$];
	audio_item_t   on_bus;
	reg_write_t    reg_on_bus;

	int unsigned items_sent  = 0;
	int unsigned items_taken = 0;
	int unsigned regs_sent   = 0;
	int unsigned regs_taken  = 0;
	int unsigned mismatches  = 0;

	// shadow of the block: register copies and envelope state
	int unsigned cfg_frames    = 1024;
	int unsigned cfg_chans     = 2;
	int unsigned cfg_width     = 512;
	logic [15:0] peak_store [PEAK_SLOTS];
	int unsigned blocks_held   = 0;
	logic [15:0] block_max     = '0;
	int unsigned block_fill    = 0;
	logic        store_overrun = 1'b0;

	// sender burst / gap shaping
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	// receiver pattern state; hold_req is raised by the sequence, consumed here
	rx_pattern_t rx_mode   = RX_OPEN;
	int unsigned mode_left = 0;
	int unsigned rx_tick   = 0;
	int unsigned hold_left = 0;
	bit          hold_req  = 1'b0;

	int unsigned idle_cycles = 0;

	waveform_peak_overview_top #(
		.MAX_BLOCKS (PEAK_SLOTS),
		.SAMPLE_BITS(16)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.sample       (sample),
		.sample_last  (sample_last),
		.pixel_index  (pixel_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_peak   (pixel_peak),
		.stored_blocks(stored_blocks),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Envelope shadow. Called once per accepted item, in acceptance order.
	// Samples fold |s| into the block max; a block closes on a full count
	// (frames * channels, zero read as one, channels capped at eight) or on
	// the last mark, and a closed block is dropped once the store is full.
	// Queries split the stored peaks over the display width.
	// ------------------------------------------------------------------
	function automatic void track_item(audio_item_t it);
		int unsigned       frames;
		int unsigned       chans;
		logic [15:0]       mag;
		longint unsigned   w;
		longint unsigned   i;
		longint unsigned   n;
		longint unsigned   lo;
		longint unsigned   hi;
		longint unsigned   j;
		pixel_result_t     r;
		case (it.cmd)
			CMD_CLEAR: begin
				blocks_held   = 0;
				block_max     = '0;
				block_fill    = 0;
				store_overrun = 1'b0;
			end
			CMD_SAMPLE: begin
				frames = (cfg_frames == 0) ? 1 : cfg_frames;
				chans  = (cfg_chans == 0) ? 1 : ((cfg_chans > 8) ? 8 : cfg_chans);
				// most negative sample wraps back to 16'h8000, i.e. 32768
				mag = it.smp[15] ? (~it.smp + 16'd1) : it.smp;
				if (mag > block_max)
					block_max = mag;
				block_fill++;
				if (block_fill >= frames * chans || it.last) begin
					if (blocks_held < PEAK_SLOTS) begin
						peak_store[blocks_held] = block_max;
						blocks_held++;
					end else begin
						store_overrun = 1'b1;
					end
					block_max  = '0;
					block_fill = 0;
				end
			end
			CMD_QUERY: begin
				w = (cfg_width == 0) ? 1 : cfg_width;
				i = it.pix;
				n = blocks_held;
				r.pix    = it.pix;
				r.peak   = '0;
				r.blocks = 13'(blocks_held);
				if (n == 0) begin
					r.st = ST_NO_DATA;
				end else if (i >= w) begin
					r.st = ST_RANGE;
				end else begin
					lo = i * n / w;
					hi = (i + 1) * n / w;
					if (hi > n)
						hi = n;
					for (j = lo; j < hi; j++)
						if (peak_store[j] > r.peak)
							r.peak = peak_store[j];
					// overflow still reports the peak
					r.st = store_overrun ? ST_OVERFLOW : ST_OK;
				end
				expected_peaks.insert(expected_peaks.size(), r);
			end
			default: ;  // unused command: no effect
		endcase
	endfunction

	function automatic void track_reg(reg_write_t wr);
		case (wr.idx)
			REG_BLOCK_FRAMES:  cfg_frames = wr.data;
			REG_CHANNEL_COUNT: cfg_chans  = wr.data[3:0];
			REG_DISPLAY_WIDTH: cfg_width  = wr.data[12:0];
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Item driver: bursts of random length, random gaps between them.
	// The bus is only reloaded once the current item is accepted.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				track_item(on_bus);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pend_items.size() != 0) begin
					on_bus = pend_items.pop_front();
					in_valid    <= 1'b1;
					command     <= on_bus.cmd;
					sample      <= on_bus.smp;
					sample_last <= on_bus.last;
					pixel_index <= on_bus.pix;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						// some long bursts with no gap at all
						burst_left = ($urandom_range(0, 3) == 0) ?
							$urandom_range(50, 150) : $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// register write driver; writes are only queued while the block is idle
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				track_reg(reg_on_bus);
				regs_taken++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (pend_regs.size() != 0) begin
					reg_on_bus = pend_regs.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= reg_on_bus.idx;
					cfg_data  <= reg_on_bus.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: switches between stall patterns every so often,
	// and honors a one-shot long hold-off requested by the sequence.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_tick++;
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_pattern_t'($urandom_range(0, 3));
					mode_left = $urandom_range(30, 200);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= $urandom_range(0, 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= ((rx_tick % 7) < 4);
				endcase
			end
		end
	end

	// result checker: each accepted result against the oldest expectation
	always @(posedge clk) begin
		pixel_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_peaks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result: peak=%0d blocks=%0d status=%0d",
						$realtime, pixel_peak, stored_blocks, status);
			end else begin
				exp_r = expected_peaks.pop_front();
				if (pixel_peak !== exp_r.peak || stored_blocks !== exp_r.blocks ||
						status !== exp_r.st) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("[%0t] pixel %0d: expected peak=%0d blocks=%0d status=%0d,",
							$realtime, exp_r.pix, exp_r.peak, exp_r.blocks, exp_r.st);
						$display(" got peak=%0d blocks=%0d status=%0d",
							pixel_peak, stored_blocks, status);
					end
				end
			end
		end
	end

	// watchdog: too long with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence helpers, all run from the negative edge
	// ------------------------------------------------------------------
	task automatic queue_item(cmd_t cmd, logic [15:0] smp, logic last, logic [11:0] pix);
		audio_item_t it;
		it.cmd  = cmd;
		it.smp  = smp;
		it.last = last;
		it.pix  = pix;
		pend_items.insert(pend_items.size(), it);
		items_sent++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] data);
		reg_write_t wr;
		wr.idx  = idx;
		wr.data = data;
		pend_regs.insert(pend_regs.size(), wr);
		regs_sent++;
		while (regs_taken != regs_sent)
			@(negedge clk);
	endtask

	// all items in, all results out, then let a trailing sample retire
	task automatic wait_quiet();
		while (items_taken != items_sent || expected_peaks.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// full-scale extremes show up often
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// random settings per phase; sometimes garbage above the used bits
	task automatic pick_random_regs();
		logic [15:0] d;
		case ($urandom_range(0, 6))
			0:       d = 16'd0;
			1:       d = 16'd1;
			2:       d = 16'd2;
			3:       d = 16'($urandom_range(3, 6));
			4:       d = 16'hFFFF;
			5:       d = 16'($urandom);
			default: d = 16'd1;
		endcase
		write_reg(REG_BLOCK_FRAMES, d);
		d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
		write_reg(REG_CHANNEL_COUNT, d);
		case ($urandom_range(0, 7))
			0:       d = 16'd0;
			1:       d = 16'd1;
			2:       d = 16'($urandom_range(2, 16));
			3:       d = 16'($urandom_range(17, 300));
			4:       d = 16'd4096;
			5:       d = 16'd8191;
			6:       d = 16'($urandom);
			default: d = 16'($urandom_range(1, 64));
		endcase
		write_reg(REG_DISPLAY_WIDTH, d);
	endtask

	// mostly samples and in-range queries, a few clears and unused commands
	task automatic queue_random_items(int unsigned count);
		int unsigned done_cnt;
		int unsigned roll;
		int unsigned w;
		logic [11:0] pix;
		done_cnt = 0;
		w = (cfg_width == 0) ? 1 : cfg_width;
		while (done_cnt < count) begin
			roll = $urandom_range(0, 99);
			pix  = 12'($urandom);
			if (roll < 3) begin
				queue_item(CMD_CLEAR, 16'($urandom), 1'($urandom), pix);
				done_cnt++;
			end else if (roll < 5) begin
				// ignored by the block, not counted
				queue_item(CMD_NONE, 16'($urandom), 1'($urandom), pix);
			end else if (roll < 35) begin
				if ($urandom_range(0, 4) != 0)
					pix = 12'($urandom_range(0, (w > 4096) ? 4095 : w - 1));
				queue_item(CMD_QUERY, 16'($urandom), 1'($urandom), pix);
				done_cnt++;
			end else begin
				queue_item(CMD_SAMPLE, pick_sample(), ($urandom_range(0, 9) == 0), pix);
				done_cnt++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned k;
		int unsigned ph;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: no data, unused command, short blocks via last mark,
		// in-range and out-of-range pixels
		queue_item(CMD_QUERY,  16'h0000, 1'b0, 12'd0);
		queue_item(CMD_NONE,   16'h7FFF, 1'b1, 12'hFFF);
		queue_item(CMD_SAMPLE, 16'h8000, 1'b1, 12'd0);
		queue_item(CMD_SAMPLE, 16'h7FFF, 1'b0, 12'd0);
		queue_item(CMD_SAMPLE, 16'h0000, 1'b1, 12'd0);
		queue_item(CMD_QUERY,  16'h0000, 1'b0, 12'd0);
		queue_item(CMD_QUERY,  16'h0000, 1'b0, 12'd511);
		queue_item(CMD_QUERY,  16'h0000, 1'b0, 12'd512);
		queue_item(CMD_QUERY,  16'h0000, 1'b0, 12'hFFF);
		wait_quiet();

		// one-sample blocks; last mark on a block that is already full
		write_reg(REG_BLOCK_FRAMES, 16'd1);
		write_reg(REG_CHANNEL_COUNT, 16'd1);
		write_reg(REG_DISPLAY_WIDTH, 16'd3);
		queue_item(CMD_SAMPLE, 16'h8000, 1'b1, 12'd0);
		queue_item(CMD_SAMPLE, 16'h7FFF, 1'b0, 12'd0);
		queue_item(CMD_SAMPLE, 16'h0000, 1'b0, 12'd0);
		queue_item(CMD_SAMPLE, 16'hFFFF, 1'b1, 12'd0);
		for (k = 0; k < 4; k++)
			queue_item(CMD_QUERY, 16'h0000, 1'b0, 12'(k));
		queue_item(CMD_CLEAR, 16'h0000, 1'b0, 12'd0);
		queue_item(CMD_QUERY, 16'h0000, 1'b0, 12'd0);
		wait_quiet();

		// largest block, channel count above eight: only the last mark closes it
		write_reg(REG_BLOCK_FRAMES, 16'hFFFF);
		write_reg(REG_CHANNEL_COUNT, 16'hFFFF);
		write_reg(REG_DISPLAY_WIDTH, 16'd2);
		queue_item(CMD_SAMPLE, 16'h1234, 1'b0, 12'd0);
		queue_item(CMD_SAMPLE, 16'hEDCC, 1'b0, 12'd0);
		queue_item(CMD_SAMPLE, 16'h8001, 1'b1, 12'd0);
		queue_item(CMD_SAMPLE, 16'h0001, 1'b0, 12'd0);
		queue_item(CMD_SAMPLE, 16'h0002, 1'b1, 12'd0);
		queue_item(CMD_QUERY,  16'h0000, 1'b0, 12'd0);
		queue_item(CMD_QUERY,  16'h0000, 1'b0, 12'd1);
		wait_quiet();

		// zero registers read as one; a long run of one-sample blocks
		write_reg(REG_BLOCK_FRAMES, 16'd0);
		write_reg(REG_CHANNEL_COUNT, 16'd0);
		write_reg(REG_DISPLAY_WIDTH, 16'd1);
		queue_item(CMD_CLEAR, 16'h0000, 1'b0, 12'd0);
		for (k = 0; k < FILL_BLOCKS; k++)
			queue_item(CMD_SAMPLE, pick_sample(), ($urandom_range(0, 7) == 0), 12'($urandom));
		queue_item(CMD_QUERY, 16'h0000, 1'b0, 12'd0);    // scans every stored peak
		queue_item(CMD_QUERY, 16'h0000, 1'b0, 12'd1);    // pixel beyond the width
		queue_item(CMD_QUERY, 16'h0000, 1'b0, 12'hFFF);
		wait_quiet();

		// widest display: ranges of zero or one peak; unused register index must not land
		write_reg(REG_DISPLAY_WIDTH, 16'd4096);
		write_reg(REG_UNUSED, 16'($urandom));
		for (k = 0; k < 16; k++)
			queue_item(CMD_QUERY, 16'($urandom), 1'($urandom), 12'($urandom));
		queue_item(CMD_QUERY, 16'h0000, 1'b0, 12'hFFF);
		wait_quiet();

		// width beyond the store: many empty ranges
		write_reg(REG_DISPLAY_WIDTH, 16'hFFFF);
		for (k = 0; k < 16; k++)
			queue_item(CMD_QUERY, 16'($urandom), 1'($urandom), 12'($urandom));
		wait_quiet();

		// random phases; the first starts from an empty store and gets the
		// long output hold-off while the sender keeps pushing
		for (ph = 0; ph < 8; ph++) begin
			pick_random_regs();
			if (ph == 0)
				queue_item(CMD_CLEAR, 16'h0000, 1'b0, 12'd0);
			queue_random_items(120);
			if (ph == 0)
				hold_req = 1'b1;
			wait_quiet();
		end

		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
